// ===== rtl/core/mws_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and the result record for the 3x3 window-sum block.
// No dependencies.
package mws_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 4096;
    localparam int SAMPLE_BITS = 20;

    localparam int WINDOW      = 3;
    localparam int CELLS       = WINDOW - 1;
    localparam int COL_BITS    = SAMPLE_BITS + $clog2(WINDOW);
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW * WINDOW);

    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int COLUMN_BITS = $clog2(MAX_COLUMNS);

    localparam int ROW_COUNT_BITS    = 13;
    localparam int COLUMN_COUNT_BITS = 11;
    localparam int CFG_DATA_BITS     = 13;
    localparam int CFG_INDEX_BITS    = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT    = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT = 1'd1;

    localparam logic [ROW_COUNT_BITS-1:0]    ROW_COUNT_RESET    = ROW_COUNT_BITS'(3);
    localparam logic [COLUMN_COUNT_BITS-1:0] COLUMN_COUNT_RESET = COLUMN_COUNT_BITS'(3);
    localparam logic [ROW_COUNT_BITS-1:0]    ROW_LIMIT    = ROW_COUNT_BITS'(MAX_ROWS);
    localparam logic [COLUMN_COUNT_BITS-1:0] COLUMN_LIMIT = COLUMN_COUNT_BITS'(MAX_COLUMNS);

    localparam int RESULT_DEPTH = 3;
    localparam int QCOUNT_BITS  = $clog2(RESULT_DEPTH + 1);
    localparam int QIDX_BITS    = $clog2(RESULT_DEPTH);

    typedef struct packed {
        logic [SUM_BITS-1:0]    best_sum;
        logic [ROW_BITS-1:0]    best_row;
        logic [COLUMN_BITS-1:0] best_column;
        logic                   size_error;
    } result_t;

    typedef struct packed {
        logic                   valid;
        logic [QCOUNT_BITS-1:0] count;
    } queue_status_t;

endpackage

// ===== rtl/core/mws_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interfaces for samples and results.
// Depends on mws_pkg.
interface mws_sample_if;
    import mws_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mws_result_if;
    import mws_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SUM_BITS-1:0]    best_sum;
    logic [ROW_BITS-1:0]    best_row;
    logic [COLUMN_BITS-1:0] best_column;
    logic                   size_error;

    modport source (output valid, output best_sum, output best_row,
                    output best_column, output size_error, input ready);
    modport sink   (input valid, input best_sum, input best_row,
                    input best_column, input size_error, output ready);
endinterface

// ===== rtl/core/mws_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/mws_column_cell.sv =====
`timescale 1ns / 1ps
// One window column cell: holds a column sum, passes it on, adds it to the running sum.
// Depends on mws_pkg.
module mws_column_cell (
    input  logic                         clk,
    input  logic                         shift,
    input  logic [mws_pkg::COL_BITS-1:0] col_in,
    output logic [mws_pkg::COL_BITS-1:0] col_q,
    input  logic [mws_pkg::SUM_BITS-1:0] acc_in,
    output logic [mws_pkg::SUM_BITS-1:0] acc_out
);
    import mws_pkg::*;

    logic [COL_BITS-1:0] col_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_q   = col_reg;
    assign acc_out = acc_in + SUM_BITS'(col_reg);
endmodule

// ===== rtl/core/mws_result_queue.sv =====
`timescale 1ns / 1ps
// Small shift-out queue for result records; head sits in entry zero.
// Depends on mws_pkg.
module mws_result_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  mws_pkg::result_t       push_data,
    input  logic                   pop,
    output mws_pkg::result_t       head,
    output mws_pkg::queue_status_t status
);
    import mws_pkg::*;

    result_t                entry_reg  [RESULT_DEPTH];
    result_t                entry_next [RESULT_DEPTH];
    logic [QCOUNT_BITS-1:0] count_reg;
    logic [QCOUNT_BITS-1:0] count_next;
    logic [QCOUNT_BITS-1:0] wr_pos;
    logic [QIDX_BITS-1:0]   wr_idx;

    assign wr_pos     = count_reg - QCOUNT_BITS'(pop);
    assign wr_idx     = wr_pos[QIDX_BITS-1:0];
    assign count_next = count_reg + QCOUNT_BITS'(push) - QCOUNT_BITS'(pop);

    // Shift on pop, then the pushed record lands behind the last kept entry.
    always_comb
    begin
        for (int i = 0; i < RESULT_DEPTH - 1; i++)
        begin
            entry_next[i] = pop ? entry_reg[i + 1] : entry_reg[i];
        end
        entry_next[RESULT_DEPTH-1] = entry_reg[RESULT_DEPTH-1];
        if (push)
        begin
            entry_next[wr_idx] = push_data;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign head         = entry_reg[0];
    assign status.valid = (count_reg != '0);
    assign status.count = count_reg;
endmodule

// ===== rtl/core/max_window_sum_3x3.sv =====
`timescale 1ns / 1ps
// Top level: largest 3x3 window sum over a row-major sample stream.
// Depends on mws_pkg, mws_if, mws_ram, mws_column_cell, mws_result_queue.
//
//  channel   role    payload                                         transfer when
//  --------  ------  ----------------------------------------------  -------------------
//  samples   sink    sample[19:0]                                    valid && ready
//  results   source  best_sum[23:0] best_row[11:0] best_column[9:0]  valid && ready
//                    size_error
//  cfg_*     write   cfg_index[0] cfg_data[12:0]                     cfg_we
//
// One sample a cycle, sustained while the result sink keeps up. The frame's last sample
// passes the line-buffer read and window adders into the stage-1 registers, then stage 2
// compares against the running best and pushes the result into the result queue.
// The result queue is three deep; ready drops only when three results are queued or
// on their way, so error streams run at full rate while the sink takes every cycle.
// Reset clears positions and running best, sets both counts to 3; line-buffer RAM is left
// as it is, since a window is only summed once two rows of the current frame are in.
module max_window_sum_3x3 (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mws_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [mws_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    mws_sample_if.sink                         samples,
    mws_result_if.source                       results
);
    import mws_pkg::*;

    // Configuration
    logic [ROW_COUNT_BITS-1:0]    row_count_reg;
    logic [COLUMN_COUNT_BITS-1:0] column_count_reg;
    logic [ROW_COUNT_BITS-1:0]    rows_eff;
    logic [COLUMN_COUNT_BITS-1:0] cols_eff;
    logic                         size_err;

    // Frame position
    logic [ROW_BITS-1:0]    row_pos_reg;
    logic [ROW_BITS-1:0]    row_pos_next;
    logic [COLUMN_BITS-1:0] col_pos_reg;
    logic [COLUMN_BITS-1:0] col_pos_next;
    logic                   last_col;
    logic                   last_row;
    logic                   win_ok;

    // Handshake
    logic                   accept;
    logic                   accept_norm;
    logic [QCOUNT_BITS:0]   pending;

    // Line buffers: upper row in the high half, middle row in the low half
    logic [COLUMN_BITS-1:0]     ram_raddr;
    logic [2*SAMPLE_BITS-1:0]   ram_wdata;
    logic [2*SAMPLE_BITS-1:0]   ram_rdata;
    logic [SAMPLE_BITS-1:0]     upper;
    logic [SAMPLE_BITS-1:0]     middle;

    // Column chain
    logic [COL_BITS-1:0] col_chain [CELLS+1];
    logic [SUM_BITS-1:0] acc_chain [CELLS+1];

    // Stage 1
    logic                   s1_win_reg;
    logic                   s1_last_reg;
    logic                   s1_err_reg;
    logic [SUM_BITS-1:0]    s1_sum_reg;
    logic [ROW_BITS-1:0]    s1_row_reg;
    logic [COLUMN_BITS-1:0] s1_col_reg;

    // Running best
    logic [SUM_BITS-1:0]    best_reg;
    logic [ROW_BITS-1:0]    best_row_reg;
    logic [COLUMN_BITS-1:0] best_col_reg;
    logic                   take;
    logic [SUM_BITS-1:0]    cand_sum;
    logic [ROW_BITS-1:0]    cand_row;
    logic [COLUMN_BITS-1:0] cand_col;

    // Result queue
    logic          push;
    logic          pop;
    result_t       push_data;
    result_t       head;
    queue_status_t q_status;

    // Counts above the buffer size are clamped; below three everything is an error.
    assign rows_eff = (row_count_reg > ROW_LIMIT) ? ROW_LIMIT : row_count_reg;
    assign cols_eff = (column_count_reg > COLUMN_LIMIT) ? COLUMN_LIMIT : column_count_reg;
    assign size_err = (rows_eff < ROW_COUNT_BITS'(WINDOW))
                   || (cols_eff < COLUMN_COUNT_BITS'(WINDOW));

    // Ready counts queued results plus one still in stage 1; no dependence on results.ready.
    assign pending       = (QCOUNT_BITS + 1)'(q_status.count)
                         + (QCOUNT_BITS + 1)'(s1_last_reg || s1_err_reg);
    assign samples.ready = (pending < (QCOUNT_BITS + 1)'(RESULT_DEPTH));
    assign accept        = samples.valid && samples.ready;
    assign accept_norm   = accept && !size_err;

    assign last_col = (COLUMN_COUNT_BITS'(col_pos_reg) + 1'b1) >= cols_eff;
    assign last_row = (ROW_COUNT_BITS'(row_pos_reg) + 1'b1) >= rows_eff;
    assign win_ok   = (row_pos_reg >= ROW_BITS'(CELLS)) && (col_pos_reg >= COLUMN_BITS'(CELLS));

    always_comb
    begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (last_col)
        begin
            col_pos_next = '0;
            row_pos_next = last_row ? '0 : row_pos_reg + 1'b1;
        end
        else
        begin
            col_pos_next = col_pos_reg + 1'b1;
        end
    end

    // Read address runs one sample ahead so the buffered column is ready at transfer.
    assign ram_raddr = cfg_we      ? '0
                     : accept_norm ? col_pos_next
                     :               col_pos_reg;

    assign upper     = ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign middle    = ram_rdata[SAMPLE_BITS-1:0];
    assign ram_wdata = {middle, samples.sample};

    mws_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (MAX_COLUMNS)
    ) u_line_ram (
        .clk   (clk),
        .we    (accept_norm),
        .waddr (col_pos_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Newest column enters the chain; each cell adds one older column to the sum.
    assign col_chain[0] = COL_BITS'(upper) + COL_BITS'(middle) + COL_BITS'(samples.sample);
    assign acc_chain[0] = SUM_BITS'(col_chain[0]);

    for (genvar g = 0; g < CELLS; g++)
    begin : g_cell
        mws_column_cell u_cell (
            .clk     (clk),
            .shift   (accept_norm),
            .col_in  (col_chain[g]),
            .col_q   (col_chain[g + 1]),
            .acc_in  (acc_chain[g]),
            .acc_out (acc_chain[g + 1])
        );
    end

    // Configuration, position and stage-1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= ROW_COUNT_RESET;
            column_count_reg <= COLUMN_COUNT_RESET;
            row_pos_reg      <= '0;
            col_pos_reg      <= '0;
            s1_win_reg       <= 1'b0;
            s1_last_reg      <= 1'b0;
            s1_err_reg       <= 1'b0;
        end
        else
        begin
            s1_win_reg  <= accept_norm && win_ok;
            s1_last_reg <= accept_norm && last_col && last_row;
            s1_err_reg  <= accept && size_err;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ROW_COUNT:    row_count_reg    <= cfg_data[ROW_COUNT_BITS-1:0];
                    REG_COLUMN_COUNT: column_count_reg <= cfg_data[COLUMN_COUNT_BITS-1:0];
                    default:          ;
                endcase
                row_pos_reg <= '0;
                col_pos_reg <= '0;
            end
            else if (accept_norm)
            begin
                row_pos_reg <= row_pos_next;
                col_pos_reg <= col_pos_next;
            end
        end
    end

    // Stage-1 payload
    always_ff @(posedge clk)
    begin
        if (accept_norm)
        begin
            s1_sum_reg <= acc_chain[CELLS];
            s1_row_reg <= row_pos_reg - ROW_BITS'(CELLS);
            s1_col_reg <= col_pos_reg - COLUMN_BITS'(CELLS);
        end
    end

    // Stage 2: strictly greater replaces, so ties keep the earliest window.
    assign take     = s1_win_reg && (s1_sum_reg > best_reg);
    assign cand_sum = take ? s1_sum_reg : best_reg;
    assign cand_row = take ? s1_row_reg : best_row_reg;
    assign cand_col = take ? s1_col_reg : best_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg     <= '0;
            best_row_reg <= '0;
            best_col_reg <= '0;
        end
        else if (cfg_we || s1_last_reg)
        begin
            best_reg     <= '0;
            best_row_reg <= '0;
            best_col_reg <= '0;
        end
        else if (take)
        begin
            best_reg     <= s1_sum_reg;
            best_row_reg <= s1_row_reg;
            best_col_reg <= s1_col_reg;
        end
    end

    assign push = s1_last_reg || s1_err_reg;

    always_comb
    begin
        push_data.best_sum    = cand_sum;
        push_data.best_row    = cand_row;
        push_data.best_column = cand_col;
        push_data.size_error  = 1'b0;
        if (s1_err_reg)
        begin
            push_data.best_sum    = '0;
            push_data.best_row    = '0;
            push_data.best_column = '0;
            push_data.size_error  = 1'b1;
        end
    end

    assign pop = results.valid && results.ready;

    mws_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    assign results.valid       = q_status.valid;
    assign results.best_sum    = head.best_sum;
    assign results.best_row    = head.best_row;
    assign results.best_column = head.best_column;
    assign results.size_error  = head.size_error;
endmodule

// ===== tb/max_window_sum_3x3_tb.sv =====
`timescale 1ns / 1ps
// Testbench for max_window_sum_3x3 with mws_pkg, mws_if: directed table, random frames and
// over-limit probes; results are checked against table records or an in-bench window model.
module max_window_sum_3x3_tb;
    import mws_pkg::*;

    localparam int SMALL_ITEMS   = 1800;  // random samples in small frames
    localparam int LIMIT_PROBE   = 60;    // samples sent with over-limit counts
    localparam int REPORT_LIMIT  = 10;
    localparam int LATENCY_PAUSE = 4;     // extra wait after the last record arrives
    localparam int GAP_PERCENT   = 26;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

    // Results that can be read off directly
    localparam result_t NO_WINDOW  = '0;
    localparam result_t SIZE_FAULT = '{best_sum: '0, best_row: '0, best_column: '0,
                                       size_error: 1'b1};
    // nine full-scale samples: 9 * 1048575
    localparam result_t ALL_MAX    = '{best_sum: 24'd9437175, best_row: '0, best_column: '0,
                                       size_error: 1'b0};

    typedef enum logic [2:0] {FILL_RANDOM, FILL_CONST, FILL_SMALL, FILL_HIGH, FILL_PEAK}
        fill_mode_t;

    typedef struct {
        bit                     set_counts;
        int unsigned            rows;
        int unsigned            cols;
        int unsigned            count;
        logic [SAMPLE_BITS-1:0] value;
        bit                     typed;
        result_t                want;
    } directed_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    mws_sample_if samples_ch ();
    mws_result_if results_ch ();

    max_window_sum_3x3 u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples_ch),
        .results   (results_ch)
    );

    // ---------------------------------------------------------------------------------
    // Window-search model: own copy of counts, line stores, window and running best
    // ---------------------------------------------------------------------------------
    logic [ROW_COUNT_BITS-1:0]    rows_reg;
    logic [COLUMN_COUNT_BITS-1:0] cols_reg;
    logic [SAMPLE_BITS-1:0]       upper_line [MAX_COLUMNS];
    logic [SAMPLE_BITS-1:0]       middle_line [MAX_COLUMNS];
    logic [SAMPLE_BITS-1:0]       window [WINDOW * WINDOW];   // oldest column first
    int                           next_row;
    int                           next_col;
    logic [SUM_BITS-1:0]          peak_sum;
    logic [ROW_BITS-1:0]          peak_row;
    logic [COLUMN_BITS-1:0]       peak_col;

    result_t window_reports [$];  // best-window records still to arrive

    bit      typed_on;
    result_t typed_want;
    bit      gaps_on   = 1'b1;
    bit      stalls_on = 1'b1;
    int      fail_count;
    int      sample_count;
    int      frame_count;
    int      fault_count;
    int      write_count;

    function automatic void restart_frame();
        next_row = 0;
        next_col = 0;
        peak_sum = '0;
        peak_row = '0;
        peak_col = '0;
    endfunction

    function automatic void clear_model();
        rows_reg = ROW_COUNT_RESET;
        cols_reg = COLUMN_COUNT_RESET;
        foreach (upper_line[i]) upper_line[i] = '0;
        foreach (middle_line[i]) middle_line[i] = '0;
        foreach (window[i]) window[i] = '0;
        restart_frame();
    endfunction

    function automatic void write_count_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                            input logic [CFG_DATA_BITS-1:0] data);
        if (idx == REG_ROW_COUNT)
            rows_reg = data[ROW_COUNT_BITS-1:0];
        else
            cols_reg = data[COLUMN_COUNT_BITS-1:0];
        restart_frame();
    endfunction

    // Returns 1 when this sample produces a result, which lands in res.
    function automatic bit scan_sample(input logic [SAMPLE_BITS-1:0] s, output result_t res);
        int                  eff_rows;
        int                  eff_cols;
        int                  r;
        int                  c;
        logic [SUM_BITS-1:0] acc;
        eff_rows = (int'(rows_reg) > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
        eff_cols = (int'(cols_reg) > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols_reg);
        res = '0;
        // undersized frame: flag it and drop the sample, state untouched
        if (eff_rows < WINDOW || eff_cols < WINDOW)
        begin
            res.size_error = 1'b1;
            return 1'b1;
        end
        r = next_row;
        c = next_col;
        for (int k = 0; k < WINDOW; k++)
        begin
            window[k * WINDOW]     = window[k * WINDOW + 1];
            window[k * WINDOW + 1] = window[k * WINDOW + 2];
        end
        window[2]      = upper_line[c];
        window[5]      = middle_line[c];
        window[8]      = s;
        upper_line[c]  = middle_line[c];
        middle_line[c] = s;
        if (r >= WINDOW - 1 && c >= WINDOW - 1)
        begin
            acc = '0;
            for (int k = 0; k < WINDOW * WINDOW; k++)
                acc = acc + SUM_BITS'(window[k]);
            // strictly greater: a tie keeps the earliest window
            if (acc > peak_sum)
            begin
                peak_sum = acc;
                peak_row = ROW_BITS'(r - (WINDOW - 1));
                peak_col = COLUMN_BITS'(c - (WINDOW - 1));
            end
        end
        if (c + 1 >= eff_cols)
        begin
            next_col = 0;
            if (r + 1 >= eff_rows)
            begin
                res.best_sum    = peak_sum;
                res.best_row    = peak_row;
                res.best_column = peak_col;
                restart_frame();
                return 1'b1;
            end
            next_row = r + 1;
        end
        else
        begin
            next_col = c + 1;
        end
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------------------------
    // Clock, sink stalls
    // ---------------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        results_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            results_ch.ready <= !stalls_on || ($urandom_range(99) >= GAP_PERCENT);
        end
    end

    // ---------------------------------------------------------------------------------
    // Monitor: register writes and sample transfers feed the model, result transfers
    // are checked against the oldest outstanding record. Model first, so even a
    // same-edge result would find its record.
    // ---------------------------------------------------------------------------------
    task automatic report(input string what, input result_t want, input result_t got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%s: expected sum %0d row %0d col %0d err %0b,",
                     what, want.best_sum, want.best_row, want.best_column, want.size_error,
                     " got sum %0d row %0d col %0d err %0b",
                     got.best_sum, got.best_row, got.best_column, got.size_error);
    endtask

    always @(posedge clk)
    begin : monitor
        result_t predicted;
        result_t want;
        result_t got;
        if (cfg_we)
        begin
            write_count_reg(cfg_index, cfg_data);
            write_count++;
        end
        if (samples_ch.valid && samples_ch.ready)
        begin
            sample_count++;
            if (scan_sample(samples_ch.sample, predicted))
                window_reports.push_back(typed_on ? typed_want : predicted);
        end
        if (results_ch.valid && results_ch.ready)
        begin
            got = '{results_ch.best_sum, results_ch.best_row, results_ch.best_column,
                    results_ch.size_error};
            if (window_reports.size() == 0)
            begin
                report("unexpected result", NO_WINDOW, got);
            end
            else
            begin
                want = window_reports.pop_front();
                if (want.size_error)
                    fault_count++;
                else
                    frame_count++;
                if (got.best_sum !== want.best_sum || got.best_row !== want.best_row ||
                    got.best_column !== want.best_column || got.size_error !== want.size_error)
                    report("result mismatch", want, got);
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------------------
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
        while (gaps_on && $urandom_range(99) < GAP_PERCENT)
        begin
            samples_ch.valid <= 1'b0;
            @(posedge clk);
        end
        samples_ch.valid  <= 1'b1;
        samples_ch.sample <= s;
        do
            @(posedge clk);
        while (!(samples_ch.valid && samples_ch.ready));
    endtask

    // Drop valid, let the monitor log the last transfer, wait for every record, then
    // give in-flight partial-frame samples time to clear the pipe.
    task automatic settle();
        samples_ch.valid <= 1'b0;
        @(posedge clk);
        while (window_reports.size() != 0)
            @(posedge clk);
        repeat (LATENCY_PAUSE) @(posedge clk);
    endtask

    // Both counts; spare high data bits on the column write are junk the block must drop.
    task automatic configure(input int unsigned rows, input int unsigned cols);
        logic [CFG_DATA_BITS-1:0] col_word;
        col_word = CFG_DATA_BITS'($urandom);
        col_word[COLUMN_COUNT_BITS-1:0] = COLUMN_COUNT_BITS'(cols);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ROW_COUNT;
        cfg_data  <= CFG_DATA_BITS'(rows);
        @(posedge clk);
        cfg_index <= REG_COLUMN_COUNT;
        cfg_data  <= col_word;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input fill_mode_t mode,
                                                           input logic [SAMPLE_BITS-1:0] base,
                                                           input bit at_peak);
        case (mode)
            FILL_CONST: return base;
            FILL_SMALL: return SAMPLE_BITS'($urandom_range(3));
            FILL_HIGH:  return SAMPLE_MAX - SAMPLE_BITS'($urandom_range(3));
            FILL_PEAK:  return at_peak ? SAMPLE_MAX : SAMPLE_BITS'($urandom_range(255));
            default:    return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic feed(input int unsigned n, input fill_mode_t mode,
                        input logic [SAMPLE_BITS-1:0] base);
        int unsigned peak_at;
        peak_at = $urandom_range(n - 1);
        for (int unsigned i = 0; i < n; i++)
            send_sample(pick_sample(mode, base, i == peak_at));
    endtask

    // ---------------------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------------------
    initial
    begin : stimulus
        directed_row_t plan [5];
        int unsigned   rows;
        int unsigned   cols;
        int unsigned   n;
        int unsigned   shape;
        int unsigned   random_sent;
        samples_ch.valid  = 1'b0;
        samples_ch.sample = '0;
        cfg_we            = 1'b0;
        cfg_index         = REG_ROW_COUNT;
        cfg_data          = '0;
        rst_n             = 1'b0;
        typed_on          = 1'b0;
        typed_want        = NO_WINDOW;
        random_sent       = 0;
        clear_model();

        // counts left at reset (3 x 3): one full-scale window
        plan[0] = '{1'b0, 3, 3, 9, SAMPLE_MAX, 1'b1, ALL_MAX};
        // undersized frames, with the opposite count at its extreme
        plan[1] = '{1'b1, 0, 2047, 1, SAMPLE_MAX, 1'b1, SIZE_FAULT};
        plan[2] = '{1'b1, 8191, 2, 1, '0, 1'b1, SIZE_FAULT};
        plan[3] = '{1'b1, 2, 0, 1, SAMPLE_MAX, 1'b1, SIZE_FAULT};
        // nothing above zero: sum 0 at the origin
        plan[4] = '{1'b1, 3, 4, 12, '0, 1'b1, NO_WINDOW};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].set_counts)
                configure(plan[i].rows, plan[i].cols);
            typed_on   = plan[i].typed;
            typed_want = plan[i].want;
            feed(plan[i].count, FILL_CONST, plan[i].value);
            settle();
            typed_on = 1'b0;
        end

        // Random frames: mostly well-formed, some undersized, some cut short.
        while (random_sent < SMALL_ITEMS)
        begin
            // long quiet stretch in the middle: no gaps, no stalls
            gaps_on   = !(random_sent >= 700 && random_sent < 1200);
            stalls_on = gaps_on;
            shape     = $urandom_range(99);
            if (shape < 12)
            begin
                if ($urandom_range(1))
                begin
                    rows = $urandom_range(2);
                    cols = $urandom_range(2047);
                end
                else
                begin
                    rows = $urandom_range(8191);
                    cols = $urandom_range(2);
                end
                configure(rows, cols);
                n = $urandom_range(1, 6);
                feed(n, FILL_RANDOM, '0);
                random_sent += n;
            end
            else
            begin
                rows = (shape < 90) ? $urandom_range(3, 7) : $urandom_range(3, 5);
                cols = (shape < 90) ? $urandom_range(3, 9) : $urandom_range(10, 40);
                configure(rows, cols);
                // back-to-back frames rely on the block clearing its best after each result
                repeat ($urandom_range(1, 3))
                begin
                    feed(rows * cols, fill_mode_t'($urandom_range(4)), SAMPLE_BITS'($urandom));
                    random_sent += rows * cols;
                end
                // abandoned frame: the next register write has to restart it
                if ($urandom_range(9) == 0)
                begin
                    n = $urandom_range(1, rows * cols - 1);
                    feed(n, FILL_RANDOM, '0);
                    random_sent += n;
                end
            end
            settle();
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;

        // Counts beyond the buffer limits: partial frames, so no result may appear
        configure(8191, 3);
        feed(LIMIT_PROBE, FILL_PEAK, '0);
        settle();
        configure(3, 2047);
        feed(LIMIT_PROBE, FILL_RANDOM, '0);
        settle();

        $display("Covered %0d samples: %0d frame results, %0d size-error results, %0d writes,",
                 sample_count, frame_count, fault_count, write_count);
        $display("frames up to 5x40, undersized, abandoned and over-limit counts, %s",
                 "with source gaps and sink stalls.");
        if (fail_count == 0 && window_reports.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run (about 2k transfers)
    initial
    begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/mws_pkg.sv
rtl/core/mws_if.sv
rtl/core/mws_ram.sv
rtl/core/mws_column_cell.sv
rtl/core/mws_result_queue.sv
rtl/core/max_window_sum_3x3.sv
tb/max_window_sum_3x3_tb.sv
